>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: implication in the next cycle");

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, expr)

`endif

`endif

>>> rtl/imoc_pkg.sv
// ----------------------------------------------------------------------------
// imoc_pkg
// Types, widths and codes shared by the IUPAC motif occurrence counter.
// ----------------------------------------------------------------------------
package imoc_pkg;

   localparam int DEFAULT_MAX_MOTIF = 16;

   localparam int BASE_W  = 3;
   localparam int COUNT_W = 16;
   localparam int LEN_W   = 5;
   localparam int MOTIF_W = 64;
   localparam int NIB_W   = 4;
   localparam int NIB_IDX_W = 4;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 64;

   typedef logic [BASE_W-1:0]  base_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [MOTIF_W-1:0] motif_type;
   typedef logic [NIB_W-1:0]   nibble_type;

   // Base codes on the input.
   localparam base_type BASE_A = 3'd0;
   localparam base_type BASE_C = 3'd1;
   localparam base_type BASE_G = 3'd2;
   localparam base_type BASE_T = 3'd3;

   // Register indexes; each register sits at byte address 8 * index.
   localparam logic [1:0] REG_MOTIF_LENGTH    = 2'd0;
   localparam logic [1:0] REG_FORWARD_MOTIF   = 2'd1;
   localparam logic [1:0] REG_REVERSE_MOTIF   = 2'd2;
   localparam logic [1:0] REG_MAX_OCCURRENCES = 2'd3;

   localparam len_type   RESET_MOTIF_LENGTH    = 5'd1;
   localparam count_type RESET_MAX_OCCURRENCES = 16'hFFFF;
   localparam count_type COUNT_MAX             = 16'hFFFF;

   // A base matches a position set only if it is one of A, C, G, T and its
   // bit is set; any other character never matches.
   function automatic logic base_in_set(base_type b, nibble_type set);
      logic hit;
      hit = 1'b0;
      case (b)
         BASE_A:  hit = set[0];
         BASE_C:  hit = set[1];
         BASE_G:  hit = set[2];
         BASE_T:  hit = set[3];
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

>>> rtl/imoc_stream_if.sv
// ----------------------------------------------------------------------------
// imoc stream interfaces
// Valid/ready channels for incoming bases and outgoing occurrence counts.
// ----------------------------------------------------------------------------
interface imoc_req_if
   import imoc_pkg::*;
();
   logic     valid;
   logic     ready;
   base_type base;
   logic     last_base;

   modport source (output valid, output base, output last_base, input ready);
   modport sink   (input valid, input base, input last_base, output ready);
endinterface

interface imoc_rsp_if
   import imoc_pkg::*;
();
   logic      valid;
   logic      ready;
   count_type occurrence_count;

   modport source (output valid, output occurrence_count, input ready);
   modport sink   (input valid, input occurrence_count, output ready);
endinterface

>>> rtl/iupac_motif_occurrence_counter.sv
// ----------------------------------------------------------------------------
// iupac_motif_occurrence_counter
// Counts windows of a base stream that match a forward or reverse-complement
// IUPAC motif and reports the capped count at the end of each sequence.
// ----------------------------------------------------------------------------
// The block takes one base word per clock cycle without gaps: a word is
// registered on accept, and when it leaves the input register the base is
// shifted into the window, the whole window is compared against both motifs
// in parallel and the count is updated. A word marked as the end of a
// sequence has its count word written to the result register as it leaves the input register. Input stalls only when an
// end-of-sequence word finds the result register still full and not taken.
// Registers are written over the APB port and take effect on the next base.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iupac_motif_occurrence_counter
   import imoc_pkg::*;
#(
   parameter int MaxMotif = DEFAULT_MAX_MOTIF
) (
   input  logic              clock,
   input  logic              reset,
   imoc_req_if.sink          req_chan,
   imoc_rsp_if.source        rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int SEEN_W = $clog2(MaxMotif + 1);

   // Configuration registers.
   len_type   motif_len_ff;
   motif_type fwd_motif_ff;
   motif_type rev_motif_ff;
   count_type max_occ_ff;

   logic       csr_write;
   logic [1:0] csr_index;
   logic       csr_aligned;

   assign pready      = 1'b1;
   assign csr_index   = paddr[4:3];
   assign csr_aligned = (paddr[2:0] == 3'd0);
   assign csr_write   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         motif_len_ff <= RESET_MOTIF_LENGTH;
         fwd_motif_ff <= '0;
         rev_motif_ff <= '0;
         max_occ_ff   <= RESET_MAX_OCCURRENCES;
      end else if (csr_write) begin
         case (csr_index)
            REG_MOTIF_LENGTH:    motif_len_ff <= pwdata[LEN_W-1:0];
            REG_FORWARD_MOTIF:   fwd_motif_ff <= pwdata;
            REG_REVERSE_MOTIF:   rev_motif_ff <= pwdata;
            REG_MAX_OCCURRENCES: max_occ_ff   <= pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_aligned) begin
         case (csr_index)
            REG_MOTIF_LENGTH:    prdata = CSR_DW'(motif_len_ff);
            REG_FORWARD_MOTIF:   prdata = fwd_motif_ff;
            REG_REVERSE_MOTIF:   prdata = rev_motif_ff;
            REG_MAX_OCCURRENCES: prdata = CSR_DW'(max_occ_ff);
            default:             prdata = '0;
         endcase
      end
   end

   // Input register.
   logic     stg_valid_ff, stg_valid_in;
   base_type stg_base_ff;
   logic     stg_last_ff;
   logic     stg_go;
   logic     req_take;

   // Result register.
   logic      rsp_valid_ff, rsp_valid_in;
   count_type rsp_count_ff;

   // An end-of-sequence word may only move on when the result slot is free.
   assign stg_go   = stg_valid_ff && !(stg_last_ff && rsp_valid_ff && !rsp_chan.ready);
   assign req_chan.ready = !stg_valid_ff || stg_go;
   assign req_take = req_chan.valid && req_chan.ready;
   assign stg_valid_in = req_take || (stg_valid_ff && !stg_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_base_ff <= req_chan.base;
         stg_last_ff <= req_chan.last_base;
      end
   end

   // Base window, entry 0 newest.
   base_type win_ff [MaxMotif];
   base_type win_in [MaxMotif];

   logic [SEEN_W-1:0] seen_ff, seen_in, seen_step;
   count_type         match_ff, match_in, match_step;
   len_type           act_len;
   logic              win_full;
   logic [MaxMotif-1:0] fwd_hit, rev_hit;
   logic              win_match;
   count_type         capped;

   // Motif length 0 acts as 1 and anything above the window depth as the depth.
   always_comb begin
      act_len = motif_len_ff;
      if (motif_len_ff == '0) begin
         act_len = LEN_W'(1);
      end else if (motif_len_ff > LEN_W'(MaxMotif)) begin
         act_len = LEN_W'(MaxMotif);
      end
   end

   always_comb begin
      win_in[0] = stg_base_ff;
      for (int j = 1; j < MaxMotif; j++) begin
         win_in[j] = win_ff[j-1];
      end
   end

   // Window entry j is compared against motif position act_len - 1 - j.
   always_comb begin
      for (int j = 0; j < MaxMotif; j++) begin
         logic [NIB_IDX_W-1:0] pos;
         logic                 used;
         pos  = NIB_IDX_W'(act_len - LEN_W'(j) - LEN_W'(1));
         used = (LEN_W'(j) < act_len);
         fwd_hit[j] = !used || base_in_set(win_in[j], fwd_motif_ff[{pos, 2'b00} +: NIB_W]);
         rev_hit[j] = !used || base_in_set(win_in[j], rev_motif_ff[{pos, 2'b00} +: NIB_W]);
      end
   end

   assign seen_step = (seen_ff < SEEN_W'(MaxMotif)) ? seen_ff + SEEN_W'(1) : seen_ff;
   assign win_full  = (LEN_W'(seen_step) >= act_len);
   assign win_match = win_full && ((&fwd_hit) || (&rev_hit));
   assign match_step = (win_match && (match_ff != COUNT_MAX)) ? match_ff + COUNT_W'(1)
                                                              : match_ff;
   assign capped = (match_step < max_occ_ff) ? match_step : max_occ_ff;

   always_comb begin
      seen_in  = seen_ff;
      match_in = match_ff;
      if (stg_go) begin
         seen_in  = stg_last_ff ? '0 : seen_step;
         match_in = stg_last_ff ? '0 : match_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         match_ff <= '0;
      end else begin
         seen_ff  <= seen_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_go) begin
         for (int j = 0; j < MaxMotif; j++) begin
            win_ff[j] <= win_in[j];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (stg_go && stg_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_go && stg_last_ff) begin
         rsp_count_ff <= capped;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.occurrence_count = rsp_count_ff;

   `ASSERT_ALWAYS(a_seen_bounded, clock, reset, seen_ff <= SEEN_W'(MaxMotif))
   `ASSERT_IMPLIES(a_count_capped, clock, reset, rsp_valid_ff, rsp_count_ff <= max_occ_ff)
   `ASSERT_NEXT(a_seq_clear, clock, reset, stg_go && stg_last_ff,
                seen_ff == '0 && match_ff == '0 && rsp_valid_ff)
   `ASSERT_NEXT(a_stage_hold, clock, reset, stg_valid_ff && !stg_go,
                stg_valid_ff && $stable(stg_base_ff) && $stable(stg_last_ff))
   `ASSERT_IMPLIES(a_go_needs_slot, clock, reset, stg_go && stg_last_ff,
                   !rsp_valid_ff || rsp_chan.ready)

endmodule
